// ===== sv/ckb_pkg.sv =====
// Package with the shared types and constants of the color-distance keyed blend.
package ckb_pkg;

  localparam int PIXEL_W = 32;
  localparam int CHAN_W = 8;
  localparam int MULT_W = 23;
  localparam int DIV_STEPS = 23;
  localparam int CNT_W = 5;

  localparam logic [2:0] REG_KEY_RED = 3'd0;
  localparam logic [2:0] REG_KEY_GREEN = 3'd1;
  localparam logic [2:0] REG_KEY_BLUE = 3'd2;
  localparam logic [2:0] REG_TOLERANCE = 3'd3;
  localparam logic [2:0] REG_TARGET_MODE = 3'd4;

  localparam logic [MULT_W-1:0] MULT_RESET = 23'd4194304;
  localparam logic [CNT_W-1:0] DIV_LAST_STEP = CNT_W'(DIV_STEPS - 1);
  localparam logic signed [33:0] ROUND_HALF = 34'sd8192;
  localparam logic signed [33:0] FULL_WEIGHT_S = 34'sd256;
  localparam logic [31:0] WEIGHT_BOUND = 32'd4186112;
  localparam logic [8:0] FULL_WEIGHT = 9'd256;
  localparam logic [7:0] CHAN_MAX = 8'd255;

  typedef struct packed {
    logic [7:0] key_red;
    logic [7:0] key_green;
    logic [7:0] key_blue;
    logic target_mode;
    logic [MULT_W-1:0] multiplier;
  } cfg_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] src;
    logic [PIXEL_W-1:0] dst;
    logic [7:0] cov;
    logic cov_on;
    logic last;
  } item_t;

  typedef struct packed {
    logic [8:0] excess;
    logic [PIXEL_W-1:0] src;
    logic [PIXEL_W-1:0] dst;
    logic [7:0] cov;
    logic cov_on;
    logic last;
  } dist_t;

  typedef struct packed {
    logic [8:0] weight;
    logic [PIXEL_W-1:0] src;
    logic [PIXEL_W-1:0] dst;
    logic last;
  } wgt_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic blended;
    logic last;
  } res_t;

endpackage

// ===== sv/ckb_cfg.sv =====
// Register file with the serial divider that derives the distance multiplier.
module ckb_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output ckb_pkg::cfg_t     cfg,
  output logic              busy
);
  import ckb_pkg::*;

  logic [2:0] index;
  logic wr;
  logic [8:0] divisor;
  logic [8:0] rem;
  logic [9:0] rem_shift;
  logic [9:0] rem_next;
  logic qbit;
  logic [MULT_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic [7:0] tolerance;

  assign pready = 1'b1;
  assign index = paddr[4:2];
  assign wr = psel && penable && pwrite && pready;

  always_comb begin
    rem_shift = {rem, (cnt == DIV_LAST_STEP)};
    qbit = (rem_shift >= {1'b0, divisor});
    rem_next = qbit ? (rem_shift - {1'b0, divisor}) : rem_shift;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_red <= '0;
      cfg.key_green <= '0;
      cfg.key_blue <= '0;
      cfg.target_mode <= 1'b0;
      cfg.multiplier <= MULT_RESET;
      tolerance <= '0;
      busy <= 1'b0;
    end else if (wr) begin
      unique case (index)
        REG_KEY_RED: cfg.key_red <= pwdata[7:0];
        REG_KEY_GREEN: cfg.key_green <= pwdata[7:0];
        REG_KEY_BLUE: cfg.key_blue <= pwdata[7:0];
        REG_TOLERANCE: begin
          tolerance <= pwdata[7:0];
          divisor <= {1'b0, pwdata[7:0]} + 9'd1;
          rem <= '0;
          quo <= '0;
          cnt <= DIV_LAST_STEP;
          busy <= 1'b1;
        end
        REG_TARGET_MODE: cfg.target_mode <= pwdata[0];
        default: ;
      endcase
    end else if (busy) begin
      rem <= rem_next[8:0];
      quo <= {quo[MULT_W-2:0], qbit};
      if (cnt == '0) begin
        busy <= 1'b0;
        cfg.multiplier <= {quo[MULT_W-2:0], qbit};
      end else begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  always_comb begin
    unique case (index)
      REG_KEY_RED: prdata = {24'd0, cfg.key_red};
      REG_KEY_GREEN: prdata = {24'd0, cfg.key_green};
      REG_KEY_BLUE: prdata = {24'd0, cfg.key_blue};
      REG_TOLERANCE: prdata = {24'd0, tolerance};
      REG_TARGET_MODE: prdata = {31'd0, cfg.target_mode};
      default: prdata = '0;
    endcase
  end

endmodule

// ===== sv/ckb_dist.sv =====
// Stage 1: max channel gap to key (inverted in target mode) as excess below full scale.
module ckb_dist (
  input  logic              clk,
  input  logic              rst,
  input  ckb_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  ckb_pkg::item_t    in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output ckb_pkg::dist_t    out_item
);
  import ckb_pkg::*;

  logic [7:0] dr;
  logic [7:0] dg;
  logic [7:0] db;
  logic [7:0] dmax;
  logic [7:0] dsel;
  logic [8:0] dwide;

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  always_comb begin
    dr = absdiff(in_item.dst[23:16], cfg.key_red);
    dg = absdiff(in_item.dst[15:8], cfg.key_green);
    db = absdiff(in_item.dst[7:0], cfg.key_blue);
    dmax = dr;
    if (dg > dmax) dmax = dg;
    if (db > dmax) dmax = db;
    dsel = cfg.target_mode ? (CHAN_MAX - dmax) : dmax;
    dwide = {1'b0, dsel} + {8'd0, dsel[7]};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item.excess <= FULL_WEIGHT - dwide;
      out_item.src <= in_item.src;
      out_item.dst <= in_item.dst;
      out_item.cov <= in_item.cov;
      out_item.cov_on <= in_item.cov_on;
      out_item.last <= in_item.last;
    end
  end

endmodule

// ===== sv/ckb_weight.sv =====
// Second and third pipeline stages: scaled distance product, then weight and coverage.
module ckb_weight (
  input  logic              clk,
  input  logic              rst,
  input  logic [22:0]       multiplier,
  input  logic              in_valid,
  output logic              in_ready,
  input  ckb_pkg::dist_t    in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output ckb_pkg::wgt_t     out_item
);
  import ckb_pkg::*;

  logic prod_valid;
  logic prod_ready;
  logic [31:0] prod;
  logic [PIXEL_W-1:0] prod_src;
  logic [PIXEL_W-1:0] prod_dst;
  logic [7:0] prod_cov;
  logic prod_cov_on;
  logic prod_last;

  logic signed [33:0] diff;
  logic signed [33:0] wsum;
  logic [8:0] w;
  logic in_range;
  logic [8:0] cov_wide;
  logic [17:0] cov_prod;
  logic [8:0] wt;

  assign in_ready = !prod_valid || prod_ready;
  assign prod_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) prod_valid <= in_valid;
      if (prod_ready) out_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      prod <= 32'({23'd0, in_item.excess} * {9'd0, multiplier});
      prod_src <= in_item.src;
      prod_dst <= in_item.dst;
      prod_cov <= in_item.cov;
      prod_cov_on <= in_item.cov_on;
      prod_last <= in_item.last;
    end
  end

  always_comb begin
    diff = ROUND_HALF - $signed({2'b00, prod});
    wsum = (diff >>> 14) + FULL_WEIGHT_S;
    w = wsum[8:0];
    in_range = (prod <= WEIGHT_BOUND);
    cov_wide = {1'b0, prod_cov} + {8'd0, prod_cov[7]};
    cov_prod = w * cov_wide;
    if (!in_range) begin
      wt = '0;
    end else if (prod_cov_on) begin
      wt = cov_prod[16:8];
    end else begin
      wt = w;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && prod_valid) begin
      out_item.weight <= wt;
      out_item.src <= prod_src;
      out_item.dst <= prod_dst;
      out_item.last <= prod_last;
    end
  end

endmodule

// ===== sv/ckb_blend.sv =====
// Last pipeline stage: per-byte blend into the output register.
module ckb_blend (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ckb_pkg::wgt_t     in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output ckb_pkg::res_t     out_item
);
  import ckb_pkg::*;

  logic [8:0] inv;
  logic [PIXEL_W-1:0] mix;
  logic [16:0] lane_sum [4];

  always_comb begin
    inv = FULL_WEIGHT - in_item.weight;
    for (int i = 0; i < 4; i++) begin
      lane_sum[i] = {9'd0, in_item.src[i*CHAN_W +: CHAN_W]} * {8'd0, in_item.weight}
                  + {9'd0, in_item.dst[i*CHAN_W +: CHAN_W]} * {8'd0, inv};
      mix[i*CHAN_W +: CHAN_W] = lane_sum[i][15:8];
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item.blended <= (in_item.weight != '0);
      out_item.pixel <= (in_item.weight != '0) ? mix : in_item.dst;
      out_item.last <= in_item.last;
    end
  end

endmodule

// ===== sv/color_distance_keyed_blend_argb_top.sv =====
// Top level of the color-distance keyed blend for premultiplied ARGB pixels.
// The block takes one pixel item per clock while s_tready is high and returns each
// result through a four-stage pipeline (key distance, distance product, weight and
// coverage, per-byte blend) whose last stage is the output register; a stalled output
// holds every stage without loss. A write to the tolerance register starts a bit-serial
// divider that computes the distance multiplier, and s_tready stays low while it runs.
// The coverage byte applies only when its flag in s_tuser is set.
module color_distance_keyed_blend_argb_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // src_pixel [31:0], dst_pixel [63:32], coverage [71:64]
  input  logic        s_tuser,  // coverage_present
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // out_pixel [31:0]
  output logic        m_tuser,  // was_blended
  output logic        m_tlast
);
  import ckb_pkg::*;

  cfg_t cfg;
  logic busy;
  item_t in_item;
  logic dist_in_ready;
  logic dist_valid;
  logic dist_ready;
  dist_t dist_item;
  logic wgt_valid;
  logic wgt_ready;
  wgt_t wgt_item;
  res_t res_item;

  ckb_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .cfg(cfg), .busy(busy)
  );

  assign in_item.src = s_tdata[31:0];
  assign in_item.dst = s_tdata[63:32];
  assign in_item.cov = s_tdata[71:64];
  assign in_item.cov_on = s_tuser;
  assign in_item.last = s_tlast;
  assign s_tready = dist_in_ready && !busy;

  ckb_dist u_dist (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(s_tvalid && !busy), .in_ready(dist_in_ready), .in_item(in_item),
    .out_valid(dist_valid), .out_ready(dist_ready), .out_item(dist_item)
  );

  ckb_weight u_weight (
    .clk(clk), .rst(rst), .multiplier(cfg.multiplier),
    .in_valid(dist_valid), .in_ready(dist_ready), .in_item(dist_item),
    .out_valid(wgt_valid), .out_ready(wgt_ready), .out_item(wgt_item)
  );

  ckb_blend u_blend (
    .clk(clk), .rst(rst),
    .in_valid(wgt_valid), .in_ready(wgt_ready), .in_item(wgt_item),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_item(res_item)
  );

  assign m_tdata = res_item.pixel;
  assign m_tuser = res_item.blended;
  assign m_tlast = res_item.last;

endmodule

// ===== dv/color_distance_keyed_blend_argb_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the color-distance keyed blend: directed table, random phases.
module color_distance_keyed_blend_argb_top_test;
  import ckb_pkg::*;

  localparam int DIR_ROWS = 15;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 185;
  localparam int SETTLE_CYCLES = 8;
  localparam longint Q_ONE = 16384;
  localparam longint Q_HALF = 8192;
  localparam int Q_SHIFT = 14;
  localparam logic [2:0] REG_UNUSED_LO = 3'd5;
  localparam logic [2:0] REG_UNUSED_HI = 3'd7;

  typedef struct {
    item_t it;
    bit    known;
    res_t  want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;  // src_pixel [31:0], dst_pixel [63:32], coverage [71:64]
  logic        s_tuser = 1'b0;  // coverage_present
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;  // out_pixel [31:0]
  logic        m_tuser;  // was_blended
  logic        m_tlast;

  cfg_t model_cfg;
  res_t pending_pixels [$];
  res_t head_res;
  int   mismatches = 0;
  int   rx_hold = 0;
  bit   steady = 1'b0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{'{32'h12345678, 32'h00000000, 8'h00, 1'b0, 1'b0}, 1'b1, '{32'h00000000, 1'b0, 1'b0}},
    '{'{32'hFFFFFFFF, 32'hFFFFFFFF, 8'h00, 1'b0, 1'b0}, 1'b1, '{32'hFFFFFFFF, 1'b1, 1'b0}},
    '{'{32'h00000000, 32'h00FF0000, 8'h00, 1'b0, 1'b1}, 1'b1, '{32'h00000000, 1'b1, 1'b1}},
    '{'{32'hA5C3E1F0, 32'h0000FF00, 8'hFF, 1'b1, 1'b0}, 1'b1, '{32'hA5C3E1F0, 1'b1, 1'b0}},
    '{'{32'hA5C3E1F0, 32'h000000FF, 8'h00, 1'b1, 1'b0}, 1'b1, '{32'h000000FF, 1'b0, 1'b0}},
    '{'{32'h5A3C1E0F, 32'hFF0000FF, 8'h00, 1'b0, 1'b1}, 1'b1, '{32'h5A3C1E0F, 1'b1, 1'b1}},
    '{'{32'h0F1E2D3C, 32'hFFFEFEFE, 8'hFF, 1'b1, 1'b0}, 1'b1, '{32'hFFFEFEFE, 1'b0, 1'b0}},
    '{'{32'hFFFFFFFF, 32'h80808080, 8'hFF, 1'b0, 1'b0}, 1'b1, '{32'h80808080, 1'b0, 1'b0}},
    '{'{32'h00000000, 32'hFFFFFFFF, 8'hFF, 1'b1, 1'b1}, 1'b1, '{32'h00000000, 1'b1, 1'b1}},
    '{'{32'hFFFFFFFF, 32'hFFFFFFFF, 8'h01, 1'b1, 1'b0}, 1'b0, '{32'h00000000, 1'b0, 1'b0}},
    '{'{32'hFFFFFFFF, 32'h00FF00FF, 8'h80, 1'b1, 1'b0}, 1'b0, '{32'h00000000, 1'b0, 1'b0}},
    '{'{32'h00000000, 32'hFFFFFFFF, 8'h7F, 1'b1, 1'b1}, 1'b0, '{32'h00000000, 1'b0, 1'b0}},
    '{'{32'hC0FFEE00, 32'hFF00FF00, 8'hFE, 1'b1, 1'b0}, 1'b0, '{32'h00000000, 1'b0, 1'b0}},
    '{'{32'h80000001, 32'h7F0000FF, 8'h81, 1'b1, 1'b0}, 1'b0, '{32'h00000000, 1'b0, 1'b0}},
    '{'{32'hFFFFFFFF, 32'h00000000, 8'hFF, 1'b1, 1'b1}, 1'b1, '{32'h00000000, 1'b0, 1'b1}}
  };

  color_distance_keyed_blend_argb_top uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [MULT_W-1:0] tol_multiplier(input logic [7:0] tol);
    return MULT_W'((256 << Q_SHIFT) / (int'(tol) + 1));
  endfunction

  function automatic res_t keyed_blend(input cfg_t c, input item_t it);
    logic [7:0] dr, dg, db, dmax;
    logic [8:0] dwide;
    longint m, t, w;
    int unsigned wt, sc, dc, v;
    res_t r;
    dr = (it.dst[23:16] > c.key_red) ? it.dst[23:16] - c.key_red : c.key_red - it.dst[23:16];
    dg = (it.dst[15:8] > c.key_green) ? it.dst[15:8] - c.key_green : c.key_green - it.dst[15:8];
    db = (it.dst[7:0] > c.key_blue) ? it.dst[7:0] - c.key_blue : c.key_blue - it.dst[7:0];
    dmax = dr;
    if (dg > dmax) dmax = dg;
    if (db > dmax) dmax = db;
    if (c.target_mode) dmax = CHAN_MAX - dmax;
    dwide = {1'b0, dmax} + 9'(dmax >> 7);
    m = longint'(c.multiplier);
    t = longint'(dwide) * m - (m - Q_ONE) * 256 + Q_HALF;
    w = t >>> Q_SHIFT;
    r.pixel = it.dst;
    r.blended = 1'b0;
    r.last = it.last;
    if (w > 0) begin
      wt = int'(w);
      if (it.cov_on) wt = (wt * (int'(it.cov) + int'(it.cov >> 7))) >> 8;
      if (wt > 0) begin
        for (int k = 0; k < 4; k++) begin
          sc = it.src[8*k +: 8];
          dc = it.dst[8*k +: 8];
          v = (sc * wt + dc * (256 - wt)) >> 8;
          r.pixel[8*k +: 8] = v[7:0];
        end
        r.blended = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (steady || pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] chan_near(input logic [7:0] k);
    int d;
    d = $urandom_range(1, 32);
    case ($urandom_range(0, 5))
      0: return 8'($urandom);
      1: return k;
      2: return ($urandom_range(0, 1) != 0) ? CHAN_MAX : 8'd0;
      3: return ~k;
      default: begin
        if ($urandom_range(0, 1) != 0) return (int'(k) + d > 255) ? CHAN_MAX : 8'(int'(k) + d);
        return (int'(k) < d) ? 8'd0 : 8'(int'(k) - d);
      end
    endcase
  endfunction

  function automatic item_t random_item(input cfg_t c);
    item_t it;
    case ($urandom_range(0, 19))
      0: it.src = '0;
      1: it.src = '1;
      default: it.src = $urandom;
    endcase
    it.dst = {8'($urandom), chan_near(c.key_red), chan_near(c.key_green), chan_near(c.key_blue)};
    case ($urandom_range(0, 5))
      0: it.cov = 8'd0;
      1: it.cov = CHAN_MAX;
      default: it.cov = 8'($urandom);
    endcase
    it.cov_on = 1'($urandom_range(0, 1));
    it.last = ($urandom_range(0, 7) == 0);
    return it;
  endfunction

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("ERROR at %0t: %s got %h want %h", $realtime, field, got, want);
    mismatches++;
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_KEY_RED: model_cfg.key_red = data[7:0];
      REG_KEY_GREEN: model_cfg.key_green = data[7:0];
      REG_KEY_BLUE: model_cfg.key_blue = data[7:0];
      REG_TOLERANCE: model_cfg.multiplier = tol_multiplier(data[7:0]);
      REG_TARGET_MODE: model_cfg.target_mode = data[0];
      default: ;
    endcase
  endtask

  task automatic set_key(input logic [7:0] kr, input logic [7:0] kg, input logic [7:0] kb,
                         input logic [7:0] tol, input logic mode);
    reg_write(REG_KEY_RED, ($urandom & 32'hFFFFFF00) | 32'(kr));
    reg_write(REG_KEY_GREEN, ($urandom & 32'hFFFFFF00) | 32'(kg));
    reg_write(REG_KEY_BLUE, ($urandom & 32'hFFFFFF00) | 32'(kb));
    reg_write(REG_TARGET_MODE, ($urandom & 32'hFFFFFFFE) | 32'(mode));
    if ($urandom_range(0, 1) != 0)
      reg_write(3'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), $urandom);
    reg_write(REG_TOLERANCE, ($urandom & 32'hFFFFFF00) | 32'(tol));
  endtask

  task automatic send_pixel(input item_t it, input res_t want);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= {it.cov, it.dst, it.src};
    s_tuser <= it.cov_on;
    s_tlast <= it.last;
    do @(posedge clk); while (!s_tready);
    pending_pixels.push_back(want);
    gap = idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] key_pick();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return CHAN_MAX;
      default: return 8'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold <= 0;
    end else if (steady) begin
      m_tready <= 1'b1;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else begin
      m_tready <= ($urandom_range(0, 3) != 0);
      rx_hold <= idle_len();
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pixels.size() == 0) begin
        report("unexpected result", m_tdata, 32'h0);
      end else begin
        head_res = pending_pixels.pop_front();
        if (m_tdata !== head_res.pixel) report("out_pixel", m_tdata, head_res.pixel);
        if (m_tuser !== head_res.blended) report("was_blended", 32'(m_tuser), 32'(head_res.blended));
        if (m_tlast !== head_res.last) report("out_last", 32'(m_tlast), 32'(head_res.last));
      end
    end
  end

  initial begin
    item_t it;
    logic [7:0] tol;
    model_cfg = '{key_red: 8'd0, key_green: 8'd0, key_blue: 8'd0, target_mode: 1'b0,
                  multiplier: tol_multiplier(8'd0)};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_pixel(dir_rows[i].it,
                 dir_rows[i].known ? dir_rows[i].want : keyed_blend(model_cfg, dir_rows[i].it));
    end
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_key(8'd0, 8'd0, 8'd0, CHAN_MAX, 1'b0);
        1: set_key(CHAN_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX, 1'b1);
        2: set_key(key_pick(), key_pick(), key_pick(), 8'd0, 1'b1);
        default: begin
          case ($urandom_range(0, 3))
            0: tol = 8'd0;
            1: tol = CHAN_MAX;
            2: tol = 8'($urandom_range(0, 15));
            default: tol = 8'($urandom);
          endcase
          set_key(key_pick(), key_pick(), key_pick(), tol, 1'($urandom_range(0, 1)));
        end
      endcase
      steady = (ph == 2 || ph == 7);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 4 && n == PHASE_ITEMS / 2) drain();
        it = random_item(model_cfg);
        send_pixel(it, keyed_blend(model_cfg, it));
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("color_distance_keyed_blend_argb_top: match");
    end else begin
      $display("color_distance_keyed_blend_argb_top: mismatch");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("color_distance_keyed_blend_argb_top: mismatch");
    $finish;
  end

endmodule
